// ===== rtl/lca_pkg.sv =====
package lca_pkg;

   // Width of one grid row as it travels on the channels.
   localparam int ROW_BITS = 32;

   // Physical columns of the grid; the active width never exceeds it.
   localparam int GRID_COLUMNS = 32;

   // Highest active width that a row can carry.
   localparam int USABLE_COLUMNS = (GRID_COLUMNS < ROW_BITS) ? GRID_COLUMNS : ROW_BITS;

   // Width of the column-count register and its value after reset.
   localparam int COLUMN_BITS = 6;
   localparam logic [COLUMN_BITS-1:0] RESET_COLUMNS = 6'd32;

   // Eight neighbors need four bits to count.
   localparam int NEIGHBOR_BITS = 4;
   localparam logic [NEIGHBOR_BITS-1:0] BIRTH_COUNT   = 4'd3;
   localparam logic [NEIGHBOR_BITS-1:0] SURVIVE_COUNT = 4'd2;

   typedef logic [ROW_BITS-1:0] row_type;

   // Bit x is set when column x is below both the programmed and the usable width.
   function automatic row_type active_mask(input logic [COLUMN_BITS-1:0] columns);
      row_type mask;
      mask = '0;
      for (int x = 0; x < ROW_BITS; x++) begin
         mask[x] = (x < USABLE_COLUMNS) && (int'(columns) > x);
      end
      return mask;
   endfunction

endpackage

// ===== rtl/lca_if.sv =====
// Input channel: one grid row per item.
interface lca_req_if;
   logic                   valid;
   logic                   ready;
   logic [lca_pkg::ROW_BITS-1:0] row_cells;
   logic                   final_row;

   modport source (output valid, output row_cells, output final_row, input ready);
   modport sink   (input valid, input row_cells, input final_row, output ready);
endinterface

// Result channel: one next-generation row per item.
interface lca_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [lca_pkg::ROW_BITS-1:0] next_cells;
   logic [lca_pkg::ROW_BITS-1:0] changed_mask;
   logic                   frame_end;

   modport source (output valid, output next_cells, output changed_mask, output frame_end,
                   input ready);
   modport sink   (input valid, input next_cells, input changed_mask, input frame_end,
                   output ready);
endinterface

// Configuration write channel for the active column count.
interface lca_csr_if;
   logic                            valid;
   logic                            ready;
   logic [lca_pkg::COLUMN_BITS-1:0] columns_in_use;

   modport source (output valid, output columns_in_use, input ready);
   modport sink   (input valid, input columns_in_use, output ready);
endinterface

// ===== rtl/lca_life_row.sv =====
module lca_life_row (
   input  lca_pkg::row_type above,
   input  lca_pkg::row_type mid,
   input  lca_pkg::row_type below,
   input  lca_pkg::row_type mask,
   output lca_pkg::row_type next_cells,
   output lca_pkg::row_type changed_mask
);

   // Rows padded with a dead cell on each side, so that edge columns need no special case.
   logic [lca_pkg::ROW_BITS+1:0] above_pad;
   logic [lca_pkg::ROW_BITS+1:0] mid_pad;
   logic [lca_pkg::ROW_BITS+1:0] below_pad;
   lca_pkg::row_type             mid_live;
   lca_pkg::row_type             next_raw;

   assign above_pad = {1'b0, above & mask, 1'b0};
   assign mid_pad   = {1'b0, mid & mask, 1'b0};
   assign below_pad = {1'b0, below & mask, 1'b0};
   assign mid_live  = mid & mask;

   // Every column counts its eight neighbors independently and applies the B3/S23 rule.
   always_comb begin
      logic [lca_pkg::NEIGHBOR_BITS-1:0] n;
      next_raw = '0;
      for (int x = 0; x < lca_pkg::ROW_BITS; x++) begin
         n = lca_pkg::NEIGHBOR_BITS'(above_pad[x]) + lca_pkg::NEIGHBOR_BITS'(above_pad[x+1])
           + lca_pkg::NEIGHBOR_BITS'(above_pad[x+2]) + lca_pkg::NEIGHBOR_BITS'(mid_pad[x])
           + lca_pkg::NEIGHBOR_BITS'(mid_pad[x+2]) + lca_pkg::NEIGHBOR_BITS'(below_pad[x])
           + lca_pkg::NEIGHBOR_BITS'(below_pad[x+1]) + lca_pkg::NEIGHBOR_BITS'(below_pad[x+2]);
         next_raw[x] = (n == lca_pkg::BIRTH_COUNT) ||
                       (mid_live[x] && (n == lca_pkg::SURVIVE_COUNT));
      end
   end

   // Cells beyond the active width stay dead and never count as changed.
   assign next_cells   = next_raw & mask;
   assign changed_mask = (next_raw ^ mid_live) & mask;

endmodule

// ===== rtl/life_cellular_automaton_row_step.sv =====
// One generation of the B3/S23 life automaton, row by row, with dead cells beyond every
// edge. Rows enter top to bottom, one per item; each row after the first produces the
// next generation of the row above it, and a row flagged final_row also produces the
// bottom row, marked frame_end, after which the held rows are cleared for the next frame.
// An item is taken into an input register and evaluated from there by one row-wide
// neighbor-count unit into a result register. Rows with zero or one result stream back
// to back while the result channel takes each result; a final row below a held row gives
// two results, which share the single life unit and the single result register, and its
// second result is loaded from the held rows after the first has been loaded. Columns at
// or above columns_in_use are dead; the user must write the width on the csr channel
// only while no row is in flight, as the block itself does not enforce it.
module life_cellular_automaton_row_step (
   input  logic          clock,
   input  logic          reset,
   lca_req_if.sink       req_chan,
   lca_rsp_if.source     rsp_chan,
   lca_csr_if.sink       csr_chan
);

   // Active column mask, rebuilt whenever the width is written.
   lca_pkg::row_type mask_ff;
   lca_pkg::row_type mask_in;

   // Input register.
   logic             in_valid_ff;
   logic             in_valid_in;
   lca_pkg::row_type in_row_ff;
   lca_pkg::row_type in_row_in;
   logic             in_final_ff;
   logic             in_final_in;

   // Held rows of the frame and the second-result phase of a final row.
   lca_pkg::row_type upper_ff;
   lca_pkg::row_type upper_in;
   lca_pkg::row_type centre_ff;
   lca_pkg::row_type centre_in;
   logic             held_ff;
   logic             held_in;
   logic             phase_ff;
   logic             phase_in;

   // Result register.
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   lca_pkg::row_type rsp_next_ff;
   lca_pkg::row_type rsp_next_in;
   lca_pkg::row_type rsp_changed_ff;
   lca_pkg::row_type rsp_changed_in;
   logic             rsp_end_ff;
   logic             rsp_end_in;

   // Sequencing.
   logic             emit;
   logic             out_can_load;
   logic             can_go;
   logic             out_load;
   logic             done;
   logic             req_take;
   lca_pkg::row_type sel_above;
   lca_pkg::row_type sel_mid;
   lca_pkg::row_type sel_below;
   logic             sel_last;
   lca_pkg::row_type life_next;
   lca_pkg::row_type life_changed;

   // Configuration writes are always taken.
   assign csr_chan.ready = 1'b1;
   assign mask_in = (csr_chan.valid) ? lca_pkg::active_mask(csr_chan.columns_in_use) : mask_ff;

   // Choose the three rows for the life unit from the held rows and the waiting item.
   always_comb begin
      if (phase_ff) begin
         sel_above = upper_ff;
         sel_mid   = centre_ff;
         sel_below = '0;
         sel_last  = 1'b1;
      end else if (held_ff) begin
         sel_above = upper_ff;
         sel_mid   = centre_ff;
         sel_below = in_row_ff;
         sel_last  = 1'b0;
      end else begin
         sel_above = '0;
         sel_mid   = in_row_ff;
         sel_below = '0;
         sel_last  = 1'b1;
      end
   end

   lca_life_row u_life_row (
      .above        (sel_above),
      .mid          (sel_mid),
      .below        (sel_below),
      .mask         (mask_ff),
      .next_cells   (life_next),
      .changed_mask (life_changed)
   );

   // The first row of a frame that is not final produces nothing.
   assign emit         = phase_ff || held_ff || in_final_ff;
   assign out_can_load = !rsp_valid_ff || rsp_chan.ready;
   assign can_go       = in_valid_ff && (!emit || out_can_load);
   assign out_load     = can_go && emit;
   assign done         = can_go && !(!phase_ff && held_ff && in_final_ff);

   assign req_chan.ready = !in_valid_ff || done;
   assign req_take       = req_chan.valid && req_chan.ready;

   // Input register loads a new item as the old one leaves.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_row_in   = in_row_ff;
      in_final_in = in_final_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_row_in   = req_chan.row_cells;
         in_final_in = req_chan.final_row;
      end else if (done) begin
         in_valid_in = 1'b0;
      end
   end

   // Held rows move down one place per row; a final row clears them after its last result.
   always_comb begin
      upper_in  = upper_ff;
      centre_in = centre_ff;
      held_in   = held_ff;
      phase_in  = phase_ff;
      if (can_go) begin
         if (phase_ff) begin
            upper_in  = '0;
            centre_in = '0;
            held_in   = 1'b0;
            phase_in  = 1'b0;
         end else if (held_ff) begin
            upper_in  = centre_ff & mask_ff;
            centre_in = in_row_ff & mask_ff;
            phase_in  = in_final_ff;
         end else if (!in_final_ff) begin
            upper_in  = '0;
            centre_in = in_row_ff & mask_ff;
            held_in   = 1'b1;
         end
      end
   end

   // Result register with its own valid; it reloads in the cycle its result is taken, and
   // while a result waits only an item that has a result to give is held back.
   assign rsp_valid_in   = out_load || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_next_in    = out_load ? life_next : rsp_next_ff;
   assign rsp_changed_in = out_load ? life_changed : rsp_changed_ff;
   assign rsp_end_in     = out_load ? sel_last : rsp_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= lca_pkg::active_mask(lca_pkg::RESET_COLUMNS);
         in_valid_ff  <= 1'b0;
         upper_ff     <= '0;
         centre_ff    <= '0;
         held_ff      <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         in_valid_ff  <= in_valid_in;
         upper_ff     <= upper_in;
         centre_ff    <= centre_in;
         held_ff      <= held_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_row_ff      <= in_row_in;
      in_final_ff    <= in_final_in;
      rsp_next_ff    <= rsp_next_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_end_ff     <= rsp_end_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.next_cells   = rsp_next_ff;
   assign rsp_chan.changed_mask = rsp_changed_ff;
   assign rsp_chan.frame_end    = rsp_end_ff;

   // The second result of a final row only exists while that row and a held centre are present.
   a_phase_needs_item: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (in_valid_ff && held_ff))
      else $error("second-result phase without a waiting final row");

   // Loading the bottom row of a frame leaves no rows held.
   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (out_load && sel_last) |=> !held_ff)
      else $error("rows still held after the bottom row of a frame");

   // With no centre held, the row above it is dead.
   a_upper_dead_when_empty: assert property (@(posedge clock) disable iff (reset)
      !held_ff |-> (upper_ff == '0))
      else $error("upper row not cleared while no centre row is held");

endmodule
